/* design/vtpd_pkg.sv */
// Package with widths, register indexes and reset values for the vertex transform.
package vtpd_pkg;
	localparam int LANE_W    = 16;
	localparam int ROW_W     = 64;
	localparam int NUM_REGS  = 6;
	localparam int IDX_W     = 3;
	localparam int FRAC_BITS_DEF = 8;
	localparam int VIEW_W    = 36;
	localparam int QUO_W     = 24;

	localparam logic [IDX_W-1:0] REG_MODEL_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_MODEL_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_MODEL_Z = 3'd2;
	localparam logic [IDX_W-1:0] REG_VIEW_X  = 3'd3;
	localparam logic [IDX_W-1:0] REG_VIEW_Y  = 3'd4;
	localparam logic [IDX_W-1:0] REG_VIEW_Z  = 3'd5;

	localparam logic [ROW_W-1:0] RST_MODEL_X = 64'h0000000000000080;
	localparam logic [ROW_W-1:0] RST_MODEL_Y = 64'h0000000000800000;
	localparam logic [ROW_W-1:0] RST_MODEL_Z = 64'h0000008000000000;
	localparam logic [ROW_W-1:0] RST_VIEW_X  = 64'h0000000000000100;
	localparam logic [ROW_W-1:0] RST_VIEW_Y  = 64'h0000000001000000;
	localparam logic [ROW_W-1:0] RST_VIEW_Z  = 64'h0500010000000000;

	typedef struct packed {
		logic signed [LANE_W-1:0] x;
		logic signed [LANE_W-1:0] y;
		logic signed [LANE_W-1:0] z;
	} vertex_t;

	typedef struct packed {
		logic signed [LANE_W-1:0] device_x;
		logic signed [LANE_W-1:0] device_y;
		logic                     divide_error;
	} result_t;
endpackage

/* design/vtpd_stream_if.sv */
// Valid/ready stream interface used for the request and result channels.
interface vtpd_stream_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/vtpd_row_cell.sv */
// Pipelined matrix row: all three products and the translation are registered together, then summed and rounded.
module vtpd_row_cell import vtpd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int IN_W      = LANE_W,
	parameter bit SATURATE  = 1'b1
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [ROW_W-1:0]          row,
	input  logic signed [IN_W-1:0]    a,
	input  logic signed [IN_W-1:0]    b,
	input  logic signed [IN_W-1:0]    c,
	output logic signed [VIEW_W-1:0]  res
);
	localparam int ACC_W = IN_W + LANE_W + 3;

	logic signed [ACC_W-1:0] pa_s1, pb_s1, pc_s1, pt_s1;
	logic signed [ACC_W-1:0] sum;
	logic signed [ACC_W-1:0] sh;
	logic signed [ACC_W-1:0] half;

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1 <= ACC_W'($signed(row[15:0]) * a);
			pb_s1 <= ACC_W'($signed(row[31:16]) * b);
			pc_s1 <= ACC_W'($signed(row[47:32]) * c);
			pt_s1 <= ACC_W'($signed(row[63:48])) <<< FRAC_BITS;
		end
	end

	always_comb begin
		half = ACC_W'(1) <<< (FRAC_BITS - 1);
		sum  = pa_s1 + pb_s1 + pc_s1 + pt_s1 + half;
		sh   = sum >>> FRAC_BITS;
		if (SATURATE) begin
			if (sh > ACC_W'(32767))
				res = VIEW_W'(32767);
			else if (sh < -ACC_W'(32768))
				res = -VIEW_W'(32768);
			else
				res = VIEW_W'(sh);
		end else begin
			res = VIEW_W'(sh);
		end
	end
endmodule

/* design/vtpd_div_cell.sv */
// One restoring-division cell: produces one quotient bit per pipeline step while en is high.
module vtpd_div_cell import vtpd_pkg::*; #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 36
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] rem_in,
	input  logic [NUM_W-1:0] quo_in,
	input  logic [DEN_W-1:0] den_in,
	output logic [NUM_W-1:0] rem_q,
	output logic [NUM_W-1:0] quo_q,
	output logic [DEN_W-1:0] den_q
);
	logic [NUM_W:0] trial;
	logic [NUM_W:0] shifted;

	always_comb begin
		shifted = {rem_in, quo_in[NUM_W-1]};
		trial   = shifted - (NUM_W+1)'(den_in);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q <= den_in;
			if (!trial[NUM_W]) begin
				rem_q <= trial[NUM_W-1:0];
				quo_q <= {quo_in[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[NUM_W-1:0];
				quo_q <= {quo_in[NUM_W-2:0], 1'b0};
			end
		end
	end
endmodule

/* design/vertex_transform_perspective_divide_top.sv */
// Top level of the vertex transform with perspective divide.
//
//  channel   dir  handshake        payload
//  vtx       in   valid/ready      x, y, z (signed Q7.8)
//  res       out  valid/ready      device_x, device_y, divide_error
//  cfg       in   cfg_we           cfg_index, cfg_data (64-bit row)
//
// One request enters per cycle while the result side is not stalled; the result leaves
// through five front stages, one one-bit divide cell per numerator bit, and the
// output register.
// Reset clears the pipeline valid bits and loads the default matrices.
// Every stage advances only when the output register is empty or being taken,
// so a stall at the result side holds the whole chain in place.
module vertex_transform_perspective_divide_top import vtpd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	vtpd_stream_if.sink      vtx,
	vtpd_stream_if.source    res,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [ROW_W-1:0] cfg_data
);
	// Numerator magnitude width: |view| << FRAC_BITS.
	localparam int NUM_W = VIEW_W + FRAC_BITS;
	localparam int NCELL = NUM_W;
	// Front stages: input register (1), model row (1), model round (1), view row (1),
	// view round (1).
	localparam int FRONT = 5;
	localparam int DEPTH = FRONT + NCELL + 1;

	logic [ROW_W-1:0] regs_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[REG_MODEL_X] <= RST_MODEL_X;
			regs_q[REG_MODEL_Y] <= RST_MODEL_Y;
			regs_q[REG_MODEL_Z] <= RST_MODEL_Z;
			regs_q[REG_VIEW_X]  <= RST_VIEW_X;
			regs_q[REG_VIEW_Y]  <= RST_VIEW_Y;
			regs_q[REG_VIEW_Z]  <= RST_VIEW_Z;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODEL_X: regs_q[REG_MODEL_X] <= cfg_data;
				REG_MODEL_Y: regs_q[REG_MODEL_Y] <= cfg_data;
				REG_MODEL_Z: regs_q[REG_MODEL_Z] <= cfg_data;
				REG_VIEW_X:  regs_q[REG_VIEW_X]  <= cfg_data;
				REG_VIEW_Y:  regs_q[REG_VIEW_Y]  <= cfg_data;
				REG_VIEW_Z:  regs_q[REG_VIEW_Z]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The whole chain moves together; the output register is the only buffer.
	logic adv;
	logic [DEPTH-1:0] vld_q;
	assign adv = !res.valid || res.ready;
	assign vtx.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[DEPTH-2:0], vtx.valid};
	end

	// Input register.
	vertex_t v_s1;
	always_ff @(posedge clk)
		if (adv) v_s1 <= vtx.data;

	// Model transform: row cells register products, round and saturate after.
	logic signed [VIEW_W-1:0] w_x, w_y, w_z;
	logic signed [LANE_W-1:0] w_s3 [3];

	vtpd_row_cell #(.FRAC_BITS(FRAC_BITS), .IN_W(LANE_W), .SATURATE(1'b1)) u_mx (
		.clk(clk), .en(adv), .row(regs_q[REG_MODEL_X]),
		.a(v_s1.x), .b(v_s1.y), .c(v_s1.z), .res(w_x));
	vtpd_row_cell #(.FRAC_BITS(FRAC_BITS), .IN_W(LANE_W), .SATURATE(1'b1)) u_my (
		.clk(clk), .en(adv), .row(regs_q[REG_MODEL_Y]),
		.a(v_s1.x), .b(v_s1.y), .c(v_s1.z), .res(w_y));
	vtpd_row_cell #(.FRAC_BITS(FRAC_BITS), .IN_W(LANE_W), .SATURATE(1'b1)) u_mz (
		.clk(clk), .en(adv), .row(regs_q[REG_MODEL_Z]),
		.a(v_s1.x), .b(v_s1.y), .c(v_s1.z), .res(w_z));

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s3[0] <= LANE_W'(w_x);
			w_s3[1] <= LANE_W'(w_y);
			w_s3[2] <= LANE_W'(w_z);
		end
	end

	// View transform: full width, no saturation.
	logic signed [VIEW_W-1:0] vw_x, vw_y, vw_z;
	logic signed [VIEW_W-1:0] vw_s5 [3];

	vtpd_row_cell #(.FRAC_BITS(FRAC_BITS), .IN_W(LANE_W), .SATURATE(1'b0)) u_vx (
		.clk(clk), .en(adv), .row(regs_q[REG_VIEW_X]),
		.a(w_s3[0]), .b(w_s3[1]), .c(w_s3[2]), .res(vw_x));
	vtpd_row_cell #(.FRAC_BITS(FRAC_BITS), .IN_W(LANE_W), .SATURATE(1'b0)) u_vy (
		.clk(clk), .en(adv), .row(regs_q[REG_VIEW_Y]),
		.a(w_s3[0]), .b(w_s3[1]), .c(w_s3[2]), .res(vw_y));
	vtpd_row_cell #(.FRAC_BITS(FRAC_BITS), .IN_W(LANE_W), .SATURATE(1'b0)) u_vz (
		.clk(clk), .en(adv), .row(regs_q[REG_VIEW_Z]),
		.a(w_s3[0]), .b(w_s3[1]), .c(w_s3[2]), .res(vw_z));

	always_ff @(posedge clk) begin
		if (adv) begin
			vw_s5[0] <= vw_x;
			vw_s5[1] <= vw_y;
			vw_s5[2] <= vw_z;
		end
	end

	// Magnitudes enter the divide chain; signs and zero flags ride alongside in a side chain.
	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic zx;
		logic zy;
		logic zden;
	} side_t;

	logic [NUM_W-1:0] nx0, ny0;
	logic [VIEW_W-1:0] d0;
	side_t side0;

	always_comb begin
		nx0 = NUM_W'(vw_s5[0][VIEW_W-1] ? -vw_s5[0] : vw_s5[0]) << FRAC_BITS;
		ny0 = NUM_W'(vw_s5[1][VIEW_W-1] ? -vw_s5[1] : vw_s5[1]) << FRAC_BITS;
		d0  = vw_s5[2][VIEW_W-1] ? -vw_s5[2] : vw_s5[2];
		side0.neg_x = vw_s5[0][VIEW_W-1] ^ vw_s5[2][VIEW_W-1];
		side0.neg_y = vw_s5[1][VIEW_W-1] ^ vw_s5[2][VIEW_W-1];
		side0.zx    = (vw_s5[0] == '0);
		side0.zy    = (vw_s5[1] == '0);
		side0.zden  = (vw_s5[2] == '0);
		// With a zero divisor the sign of the numerator alone decides.
		if (side0.zden) begin
			side0.neg_x = vw_s5[0][VIEW_W-1];
			side0.neg_y = vw_s5[1][VIEW_W-1];
		end
	end

	logic [NUM_W-1:0]  rx [NCELL+1];
	logic [NUM_W-1:0]  qx [NCELL+1];
	logic [NUM_W-1:0]  ry [NCELL+1];
	logic [NUM_W-1:0]  qy [NCELL+1];
	logic [VIEW_W-1:0] dx [NCELL+1];
	logic [VIEW_W-1:0] dy [NCELL+1];
	side_t             sd [NCELL+1];

	assign rx[0] = '0;
	assign qx[0] = nx0;
	assign ry[0] = '0;
	assign qy[0] = ny0;
	assign dx[0] = d0;
	assign dy[0] = d0;
	assign sd[0] = side0;

	for (genvar i = 0; i < NCELL; i++) begin : g_div
		vtpd_div_cell #(.NUM_W(NUM_W), .DEN_W(VIEW_W)) u_cx (
			.clk(clk), .en(adv), .rem_in(rx[i]), .quo_in(qx[i]), .den_in(dx[i]),
			.rem_q(rx[i+1]), .quo_q(qx[i+1]), .den_q(dx[i+1]));
		vtpd_div_cell #(.NUM_W(NUM_W), .DEN_W(VIEW_W)) u_cy (
			.clk(clk), .en(adv), .rem_in(ry[i]), .quo_in(qy[i]), .den_in(dy[i]),
			.rem_q(ry[i+1]), .quo_q(qy[i+1]), .den_q(dy[i+1]));
		always_ff @(posedge clk)
			if (adv) sd[i+1] <= sd[i];
	end

	// Final sign fix and clamp into the output register.
	function automatic logic [LANE_W:0] finish(input logic [NUM_W-1:0] q,
		input logic neg, input logic zn, input logic zd);
		logic [LANE_W-1:0] v;
		logic              e;
		begin
			e = 1'b0;
			if (zd) begin
				e = 1'b1;
				v = zn ? '0 : (neg ? 16'h8000 : 16'h7fff);
			end else if (neg) begin
				if (q > NUM_W'(32768)) begin
					v = 16'h8000; e = 1'b1;
				end else begin
					v = LANE_W'(-q);
				end
			end else begin
				if (q > NUM_W'(32767)) begin
					v = 16'h7fff; e = 1'b1;
				end else begin
					v = LANE_W'(q);
				end
			end
			finish = {e, v};
		end
	endfunction

	logic [LANE_W:0] fx, fy;
	result_t out_q;
	assign fx = finish(qx[NCELL], sd[NCELL].neg_x, sd[NCELL].zx, sd[NCELL].zden);
	assign fy = finish(qy[NCELL], sd[NCELL].neg_y, sd[NCELL].zy, sd[NCELL].zden);

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.device_x     <= fx[LANE_W-1:0];
			out_q.device_y     <= fy[LANE_W-1:0];
			out_q.divide_error <= fx[LANE_W] | fy[LANE_W];
		end
	end

	assign res.valid = vld_q[DEPTH-1];
	assign res.data  = out_q;
endmodule
